### rtl/core/ash_pkg.sv
// Package for the AS path one-at-a-time hash block.
// Holds the field widths, command codes, the classified operation type
// and the mixing and avalanche functions. It depends on nothing else.
`timescale 1ns / 1ps

package ash_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 16;
    localparam int HASH_W  = 32;
    localparam int IDX_W   = 6;

    localparam logic [CMD_W-1:0] CMD_TYPE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ASN    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    localparam logic [IDX_W-1:0] INDEX_BITS_RESET = 6'd16;

    typedef enum logic [1:0] {
        OP_TYPE,
        OP_ASN,
        OP_FINISH
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [VALUE_W-1:0] value;
        logic               finish;
    } ash_op_t;

    function automatic logic [HASH_W-1:0] mix_round(
        input logic [HASH_W-1:0] h_in,
        input logic [HASH_W-1:0] v
    );
        logic [HASH_W-1:0] h;
        h = h_in + v;
        h = h + (h << 10);
        h = h ^ (h >> 6);
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] avalanche(input logic [HASH_W-1:0] h_in);
        logic [HASH_W-1:0] h;
        h = h_in + (h_in << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] index_mask(input logic [IDX_W-1:0] bits);
        logic [HASH_W-1:0] m;
        if (bits >= IDX_W'(HASH_W))
        begin
            m = '1;
        end
        else
        begin
            m = ~({HASH_W{1'b1}} << bits[4:0]);
        end
        return m;
    endfunction

endpackage

### rtl/core/ash_front.sv
// Front end of the AS path hash block: accepts input transactions,
// classifies each command and holds the operations in a two-entry queue.
// Depends on ash_pkg.
`timescale 1ns / 1ps

module ash_front
    import ash_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    output logic               op_valid,
    output ash_op_t            op,
    input  logic               op_pop
);

    ash_op_t     slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;
    ash_op_t     classified;

    always_comb
    begin
        classified.value  = value;
        classified.finish = last;
        unique case (cmd)
            CMD_TYPE:
            begin
                classified.kind = OP_TYPE;
            end
            CMD_ASN:
            begin
                classified.kind = OP_ASN;
            end
            default:
            begin
                classified.kind   = OP_FINISH;
                classified.finish = 1'b1;
            end
        endcase
    end

    assign full     = (count_reg == 2'd2);
    assign op_valid = (count_reg != 2'd0);
    assign op       = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = op_pop && op_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

### rtl/core/ash_back.sv
// Back end of the AS path hash block: absorbs operations into the running
// hash, finalises finished paths in a separate stage and queues the results.
// Depends on ash_pkg.
`timescale 1ns / 1ps

module ash_back
    import ash_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  ash_op_t           op,
    output logic              op_pop,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_wdata,
    output logic              empty,
    input  logic              pop,
    output logic [HASH_W-1:0] hash_index
);

    logic [HASH_W-1:0] running_hash_reg;
    logic [HASH_W-1:0] running_hash_next;
    logic [IDX_W-1:0]  index_bits_reg;
    logic [HASH_W-1:0] fin_hash_reg;
    logic              fin_valid_reg;
    logic              fin_valid_next;
    logic [HASH_W-1:0] out_slot_reg [2];
    logic              out_wr_ptr_reg;
    logic              out_rd_ptr_reg;
    logic [1:0]        out_count_reg;
    logic [1:0]        out_count_next;
    logic [HASH_W-1:0] absorbed;
    logic              out_room;
    logic              fin_ready;
    logic              fin_move;
    logic              out_pop;

    always_comb
    begin
        case (op.kind)
            OP_TYPE:
            begin
                absorbed = mix_round(running_hash_reg, {16'd0, op.value});
            end
            OP_ASN:
            begin
                absorbed = mix_round(mix_round(running_hash_reg, {24'd0, op.value[7:0]}),
                                     {24'd0, op.value[15:8]});
            end
            default:
            begin
                absorbed = running_hash_reg;
            end
        endcase
    end

    assign out_room  = (out_count_reg != 2'd2);
    assign fin_ready = !fin_valid_reg || out_room;
    assign fin_move  = fin_valid_reg && out_room;
    assign op_pop    = op_valid && (!op.finish || fin_ready);
    assign out_pop   = pop && !empty;
    assign empty     = (out_count_reg == 2'd0);
    assign hash_index = out_slot_reg[out_rd_ptr_reg];

    always_comb
    begin
        running_hash_next = running_hash_reg;
        if (op_pop)
        begin
            running_hash_next = op.finish ? '0 : absorbed;
        end
        fin_valid_next = (fin_valid_reg && !out_room) || (op_pop && op.finish);
        out_count_next = out_count_reg + {1'b0, fin_move} - {1'b0, out_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= '0;
            index_bits_reg   <= INDEX_BITS_RESET;
            fin_valid_reg    <= 1'b0;
            out_wr_ptr_reg   <= 1'b0;
            out_rd_ptr_reg   <= 1'b0;
            out_count_reg    <= 2'd0;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
            fin_valid_reg    <= fin_valid_next;
            out_count_reg    <= out_count_next;
            if (cfg_we)
            begin
                index_bits_reg <= cfg_wdata;
            end
            if (fin_move)
            begin
                out_wr_ptr_reg <= ~out_wr_ptr_reg;
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= ~out_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop && op.finish)
        begin
            fin_hash_reg <= absorbed;
        end
        if (fin_move)
        begin
            out_slot_reg[out_wr_ptr_reg] <= avalanche(fin_hash_reg) &
                                            index_mask(index_bits_reg);
        end
    end

endmodule

### rtl/core/as_path_one_at_a_time_hash.sv
// Top level of the AS path one-at-a-time hash block.
// Joins the front end (ash_front) and the back end (ash_back); uses ash_pkg.
//
// Input channel: a transaction is taken when push is high and full is low.
// cmd selects a segment type word, an AS number (two byte rounds, low byte
// first) or finish only; last asks for the hash to be finalised after the
// item is absorbed. Finish only always finalises, and so does the unused
// command code.
// Result channel: while empty is low, hash_index holds the oldest result;
// it is taken when pop is high. Each finalising item gives one result, the
// finalised hash masked to its index_bits low bits, and clears the hash.
// index_bits is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, which the block does not enforce. It resets to
// 16; values of 32 or more keep the full hash. Throughput is one item per
// cycle, set by the running-hash update, which absorbs a whole item, unless a
// finishing item waits for the finalise stage. A result passes through the front
// queue, the finalise stage and the result queue. If pop stays low, the result
// queue and the finalise stage fill; the next finishing item then waits at the
// head of the two-entry front queue, which fills, and full rises. Reset empties both queues and clears the hash.
`timescale 1ns / 1ps

module as_path_one_at_a_time_hash
    import ash_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    output logic               empty,
    input  logic               pop,
    output logic [HASH_W-1:0]  hash_index,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_wdata
);

    logic    op_valid;
    ash_op_t op;
    logic    op_pop;

    ash_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .value    (value),
        .last     (last),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop)
    );

    ash_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_valid),
        .op         (op),
        .op_pop     (op_pop),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .empty      (empty),
        .pop        (pop),
        .hash_index (hash_index)
    );

`ifndef SYNTH
    a_full_needs_results: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("front queue full while no result is waiting");

    a_pop_needs_op: assert property (@(posedge clk) disable iff (!rst_n)
        op_pop |-> op_valid)
        else $error("back end took an operation from an empty front queue");

    a_plain_op_absorbed: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && !op.finish) |-> op_pop)
        else $error("back end stalled on an operation that gives no result");
`endif

endmodule

### verif/as_path_one_at_a_time_hash_tb.sv
// Self-checking testbench for as_path_one_at_a_time_hash: AS paths go in through a push/full
// queue interface, and table sizes go in through the configuration port. Hash indexes are checked
// in order against a predictor of the hash. Depends on ash_pkg and the block's RTL only.
`timescale 1ns / 1ps

module as_path_one_at_a_time_hash_tb;
    import ash_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int IDLE_PERCENT = 7;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 160;
    localparam int PHASES       = 9;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic               last;
    } path_item_t;

    class path_hash_tracker;
        bit [HASH_W-1:0] running;
        bit [IDX_W-1:0]  table_bits;
        bit [HASH_W-1:0] expected_index_q[$];
        int              failures;

        function new();
            running    = '0;
            table_bits = INDEX_BITS_RESET;
            failures   = 0;
        endfunction

        function bit [HASH_W-1:0] absorb_round(bit [HASH_W-1:0] h, bit [HASH_W-1:0] v);
            bit [HASH_W-1:0] t;
            t = h + v;
            t = t + (t << 10);
            t = t ^ (t >> 6);
            return t;
        endfunction

        function bit [HASH_W-1:0] final_mix(bit [HASH_W-1:0] h);
            bit [HASH_W-1:0] t;
            t = h + (h << 3);
            t = t ^ (t >> 11);
            t = t + (t << 15);
            return t;
        endfunction

        // Notes one accepted transaction and queues its hash index if it finalises the path.
        function void absorb_item(bit [CMD_W-1:0] c, bit [VALUE_W-1:0] v, bit l);
            bit [HASH_W-1:0] h;
            bit [HASH_W-1:0] mask;
            bit              done;
            h    = running;
            done = l;
            case (c)
                CMD_TYPE:
                begin
                    h = absorb_round(h, HASH_W'(v));
                end
                CMD_ASN:
                begin
                    h = absorb_round(h, HASH_W'(v[7:0]));
                    h = absorb_round(h, HASH_W'(v[15:8]));
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
            if (!done)
            begin
                running = h;
                return;
            end
            if (table_bits >= 32)
            begin
                mask = '1;
            end
            else
            begin
                mask = (HASH_W'(1) << table_bits) - HASH_W'(1);
            end
            expected_index_q.push_back(final_mix(h) & mask);
            running = '0;
        endfunction

        function void match_index(bit [HASH_W-1:0] got);
            bit [HASH_W-1:0] want;
            if (expected_index_q.size() == 0)
            begin
                $error("hash_index: no result expected, actual %h", got);
                failures++;
                return;
            end
            want = expected_index_q.pop_front();
            if (got !== want)
            begin
                $error("hash_index mismatch: expected %h, actual %h", want, got);
                failures++;
            end
        endfunction

        function int waiting();
            return expected_index_q.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [CMD_W-1:0]   cmd = '0;
    logic [VALUE_W-1:0] value = '0;
    logic               last = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [HASH_W-1:0]  hash_index;
    logic               cfg_we = 1'b0;
    logic [IDX_W-1:0]   cfg_wdata = '0;

    path_hash_tracker tracker = new();
    bit               no_idle = 1'b0;
    bit               hold_req = 1'b0;
    int               sent_items = 0;

    as_path_one_at_a_time_hash dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .value      (value),
        .last       (last),
        .empty      (empty),
        .pop        (pop),
        .hash_index (hash_index),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function bit take_break();
        return !no_idle && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    function logic [VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
        begin
            return VALUE_W'($urandom_range(255));
        end
        else if (r < 30)
        begin
            return ($urandom_range(1) == 0) ? '0 : '1;
        end
        return VALUE_W'($urandom);
    endfunction

    // Called and returning at a falling edge; push stays high for a following transaction.
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v,
                             input logic l);
        while (take_break())
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push  <= 1'b1;
        cmd   <= c;
        value <= v;
        last  <= l;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        tracker.absorb_item(c, v, l);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic send_path();
        path_item_t items[$];
        path_item_t it;
        int         segs;
        int         asns;
        segs = $urandom_range(1, 3);
        for (int s = 0; s < segs; s++)
        begin
            it.cmd  = CMD_TYPE;
            it.last = 1'b0;
            if ($urandom_range(9) == 0)
            begin
                it.value = pick_value();
            end
            else
            begin
                it.value = VALUE_W'($urandom_range(1, 2));
            end
            items.push_back(it);
            asns = $urandom_range(0, 6);
            for (int a = 0; a < asns; a++)
            begin
                it.cmd   = CMD_ASN;
                it.value = pick_value();
                items.push_back(it);
            end
        end
        if ($urandom_range(99) < 70)
        begin
            items[items.size() - 1].last = 1'b1;
        end
        else
        begin
            it.cmd   = ($urandom_range(3) == 0) ? CMD_SPARE : CMD_FINISH;
            it.value = VALUE_W'($urandom);
            it.last  = 1'($urandom_range(1));
            items.push_back(it);
        end
        foreach (items[i])
        begin
            send_item(items[i].cmd, items[i].value, items[i].last);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            send_item(CMD_W'($urandom_range(3)), VALUE_W'($urandom),
                      1'($urandom_range(99) < 30));
        end
    endtask

    // Waits until every expected hash index has come out, then writes the table size.
    task automatic write_table_bits(input logic [IDX_W-1:0] bits);
        push <= 1'b0;
        while (tracker.waiting() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(negedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_wdata <= bits;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.table_bits = bits;
    endtask

    initial
    begin
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                end
            end
            pop <= !take_break();
            @(posedge clk);
            if (pop && !empty)
            begin
                tracker.match_index(hash_index);
            end
            @(negedge clk);
        end
    end

    initial
    begin
        int settings[PHASES];
        int start;
        settings = '{16, 0, 32, 1, 63, 31, 33, 0, 0};
        settings[7] = $urandom_range(2, 30);
        settings[8] = $urandom_range(63);

        repeat (10)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty paths, the spare command, extreme values and finishing with state absorbed.
        send_item(CMD_FINISH, 16'h0000, 1'b0);
        send_item(CMD_SPARE,  16'hFFFF, 1'b0);
        send_item(CMD_SPARE,  16'h0000, 1'b1);
        send_item(CMD_TYPE,   16'h0001, 1'b0);
        send_item(CMD_ASN,    16'h0000, 1'b0);
        send_item(CMD_ASN,    16'hFFFF, 1'b1);
        send_item(CMD_TYPE,   16'h0002, 1'b0);
        send_item(CMD_ASN,    16'h1234, 1'b0);
        send_item(CMD_TYPE,   16'hFFFF, 1'b0);
        send_item(CMD_TYPE,   16'h0000, 1'b1);
        send_item(CMD_ASN,    16'hFFFF, 1'b0);
        send_item(CMD_SPARE,  16'h5A5A, 1'b1);
        send_item(CMD_TYPE,   16'hFFFF, 1'b1);
        send_item(CMD_ASN,    16'h00FF, 1'b0);
        send_item(CMD_ASN,    16'hFF00, 1'b0);
        send_item(CMD_FINISH, 16'hFFFF, 1'b1);
        send_item(CMD_TYPE,   16'h0002, 1'b0);
        send_item(CMD_FINISH, 16'hA5A5, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                write_table_bits(IDX_W'(settings[p]));
            end
            no_idle = (p == 2);
            if (p == 4)
            begin
                hold_req = 1'b1;
            end
            start = sent_items;
            while (sent_items - start < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 15)
                begin
                    send_noise();
                end
                else
                begin
                    send_path();
                end
            end
        end
        no_idle = 1'b0;
        push <= 1'b0;

        while (tracker.waiting() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(negedge clk);
        end
        if (tracker.failures == 0)
        begin
            $display("** as_path_one_at_a_time_hash: PASSED **");
        end
        else
        begin
            $display("** as_path_one_at_a_time_hash: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #200000;
        $display("** as_path_one_at_a_time_hash: FAILED **");
        $finish;
    end

endmodule
